[rtl/audio_frame_cadence_locator_assert.svh]
// Assertion macros shared by the frame cadence locator modules
`ifndef AUDIO_FRAME_CADENCE_LOCATOR_ASSERT_SVH
`define AUDIO_FRAME_CADENCE_LOCATOR_ASSERT_SVH

// consequent checked in the same cycle
`define AFCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define AFCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/afcl_pkg.sv]
// Shared types, widths and cadence tables of the frame cadence locator
package afcl_pkg;

    localparam int CADENCE_LEN_DEF = 5;
    localparam int OFFSET_BITS_DEF = 48;

    localparam int POS_W    = 40;
    localparam int SIZE_W   = 48;
    localparam int OFS_W    = 48;
    localparam int FBYTES_W = 19;
    localparam int SAMP_W   = 11;
    localparam int COUNT_W  = 40;
    localparam int CHAN_W   = 5;
    localparam int SBITS_W  = 6;
    localparam int BPS_W    = 8;
    localparam int CSAMP_W  = 13;
    localparam int CYCB_W   = 21;
    localparam int DVD_W    = 48;
    localparam int ACC_W    = 48;

    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    localparam int S_TDATA_W = POS_W + SIZE_W;
    localparam int M_TDATA_W = 120;

    localparam logic [SAMP_W-1:0] SAMPLES_25   = 11'd1920;
    localparam logic [SAMP_W-1:0] SAMPLES_LONG = 11'd1602;
    localparam logic [SAMP_W-1:0] SAMPLES_SHORT = 11'd1601;

    typedef struct packed {
        logic                mode;
        logic [CHAN_W-1:0]   channels;
        logic [SBITS_W-1:0]  sample_bits;
        logic [SIZE_W-1:0]   start;
        logic [SIZE_W-1:0]   limit;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [SAMP_W-1:0] ntsc_samples(input int unsigned slot);
        logic [SAMP_W-1:0] s;
        case (slot) inside
            32'd1, 32'd3: s = SAMPLES_SHORT;
            default:      s = SAMPLES_LONG;
        endcase
        return s;
    endfunction

    function automatic int unsigned ntsc_prefix(input int unsigned slot);
        int unsigned s;
        s = 0;
        for (int i = 0; i < 5; i++)
        begin
            if (i < slot)
            begin
                s = s + 32'(ntsc_samples(i));
            end
        end
        return s;
    endfunction

    function automatic int unsigned ntsc_cadence_sum(input int unsigned len);
        int unsigned s;
        s = 0;
        for (int i = 0; i < 5; i++)
        begin
            if (i < len)
            begin
                s = s + 32'(ntsc_samples(i));
            end
        end
        return s;
    endfunction

endpackage

[rtl/afcl_regs.sv]
// Configuration register file with APB-style access
module afcl_regs
    import afcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    localparam int IDX_W = APB_AW - 3;

    localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CHANNELS = 3'd1;
    localparam logic [IDX_W-1:0] REG_SBITS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_START    = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd4;

    localparam logic [CHAN_W-1:0]  RST_CHANNELS = 5'd2;
    localparam logic [SBITS_W-1:0] RST_SBITS    = 6'd24;

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:3];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= 1'b0;
            cfg_reg.channels    <= RST_CHANNELS;
            cfg_reg.sample_bits <= RST_SBITS;
            cfg_reg.start       <= '0;
            cfg_reg.limit       <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODE:     cfg_reg.mode        <= pwdata[0];
                REG_CHANNELS: cfg_reg.channels    <= pwdata[CHAN_W-1:0];
                REG_SBITS:    cfg_reg.sample_bits <= pwdata[SBITS_W-1:0];
                REG_START:    cfg_reg.start       <= pwdata[SIZE_W-1:0];
                REG_LIMIT:    cfg_reg.limit       <= pwdata[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:     prdata = APB_DW'(cfg_reg.mode);
            REG_CHANNELS: prdata = APB_DW'(cfg_reg.channels);
            REG_SBITS:    prdata = APB_DW'(cfg_reg.sample_bits);
            REG_START:    prdata = APB_DW'(cfg_reg.start);
            REG_LIMIT:    prdata = APB_DW'(cfg_reg.limit);
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/afcl_serdiv.sv]
// Bit-serial restoring divider with a shift-and-add quotient accumulator
`include "audio_frame_cadence_locator_assert.svh"

module afcl_serdiv
    import afcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [CYCB_W-1:0] divisor,
    input  logic [ACC_W-1:0]  addend,
    output div_status_t       status,
    output logic [ACC_W-1:0]  acc,
    output logic [CYCB_W-1:0] remainder
);

    localparam int              CNT_W    = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CYCB_W-1:0] dvs_reg, dvs_next;
    logic [ACC_W-1:0]  add_reg, add_next;
    logic [CYCB_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [CYCB_W:0]   rem_shift;
    logic [CYCB_W:0]   rem_diff;
    logic              take;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign take      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        add_next  = add_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            add_next  = addend;
            rem_next  = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = take ? rem_diff[CYCB_W-1:0] : rem_shift[CYCB_W-1:0];
            acc_next = {acc_reg[ACC_W-2:0], 1'b0} + (take ? add_reg : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        add_reg <= add_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign acc         = acc_reg;
    assign remainder   = rem_reg;

    `AFCL_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider not busy after start")
    `AFCL_ASSERT_SAME(a_done_after_busy, done_reg, $past(busy_reg), "done without a busy run")
    `AFCL_ASSERT_NEXT(a_last_done, busy_reg && !start && cnt_reg == CNT_LAST,
        done_reg && !busy_reg, "divider missed its final step")

endmodule

[rtl/audio_frame_cadence_locator.sv]
// Top level of the audio frame cadence locator: control sequencer and output register
//
//  channel   dir   handshake                  contents
//  s_*       in    s_tvalid / s_tready        item: kind, frame position, file size
//  m_*       out   m_tvalid / m_tready        item: ok, offset, bytes, samples, count
//  apb       in    psel & penable & pwrite    configuration registers, 8-byte stride
//
//  Each item passes LEN, CYC and LOAD, then the 48-step bit-serial divider, then PRE
//  and ADD for a locate or TAIL for a measure, then OUT; a locate at or past the
//  duration goes from LOAD straight to OUT. One item is worked on at a time, and
//  the next is accepted while a finished result waits in the output register. Reset
//  clears the duration and all control state; an output stall holds the FSM in OUT.
`include "audio_frame_cadence_locator_assert.svh"

module audio_frame_cadence_locator
    import afcl_pkg::*;
#(
    parameter int CADENCE_LEN = CADENCE_LEN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // frame_position[39:0], file_size[87:40]
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // byte_offset[47:0], frame_bytes[66:48],
                                            // samples_in_frame[77:67], frame_count[117:78]
    output logic                 m_tuser    // ok
);

    localparam int OFF_W       = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;
    localparam int CAD_W       = $clog2(CADENCE_LEN + 1);
    localparam int CYC_SAMPLES = ntsc_cadence_sum(CADENCE_LEN);
    localparam int M_PAD_W     = M_TDATA_W - (OFS_W + FBYTES_W + SAMP_W + COUNT_W);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LEN  = 4'd1;
    localparam logic [3:0] ST_CYC  = 4'd2;
    localparam logic [3:0] ST_LOAD = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_TAIL = 4'd5;
    localparam logic [3:0] ST_PRE  = 4'd6;
    localparam logic [3:0] ST_ADD  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    cfg_t        cfg;
    div_status_t div_status;

    logic [3:0]          state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SIZE_W-1:0]   len_reg, len_next;
    logic                ok_reg, ok_next;
    logic [BPS_W-1:0]    bps_reg, bps_next;
    logic [CYCB_W-1:0]   cycb_reg, cycb_next;
    logic [CYCB_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]  dacc_reg, dacc_next;
    logic [COUNT_W-1:0]  dur_reg, dur_next;
    logic [CAD_W-1:0]    slot_reg, slot_next;
    logic [CYCB_W-1:0]   pre_reg, pre_next;
    logic [FBYTES_W-1:0] fbytes_reg, fbytes_next;
    logic [OFF_W-1:0]    off_reg, off_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_ok_reg, m_ok_next;
    logic [OFS_W-1:0]    m_off_reg, m_off_next;
    logic [FBYTES_W-1:0] m_fbytes_reg, m_fbytes_next;
    logic [SAMP_W-1:0]   m_samp_reg, m_samp_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dividend;
    logic [CYCB_W-1:0]       div_divisor;
    logic [ACC_W-1:0]        div_addend;
    logic [ACC_W-1:0]        div_acc;
    logic [CYCB_W-1:0]       div_rem;

    logic [CAD_W-1:0]        n_val;
    logic [CSAMP_W-1:0]      csamp;
    logic [SBITS_W:0]        sb_round;
    logic [CHAN_W+3:0]       bps_full;
    logic [SAMP_W-1:0]       slot_samples;
    logic [CYCB_W-1:0]       slot_bytes;
    logic [CSAMP_W-1:0]      pre_samples;
    logic                    out_load;
    logic                    loc_ok;

    afcl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afcl_serdiv u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .addend    (div_addend),
        .status    (div_status),
        .acc       (div_acc),
        .remainder (div_rem)
    );

    assign n_val        = cfg.mode ? CAD_W'(CADENCE_LEN) : CAD_W'(1);
    assign csamp        = cfg.mode ? CSAMP_W'(CYC_SAMPLES) : CSAMP_W'(SAMPLES_25);
    assign sb_round     = {1'b0, cfg.sample_bits} + 7'd7;
    assign bps_full     = cfg.channels * sb_round[SBITS_W:3];
    assign slot_samples = cfg.mode ? ntsc_samples(32'(slot_reg)) : SAMPLES_25;
    assign slot_bytes   = slot_samples * bps_reg;
    assign pre_samples  = CSAMP_W'(ntsc_prefix(32'(slot_reg)));
    assign loc_ok       = !kind_reg && ok_reg;

    assign div_dividend = kind_reg ? len_reg : DVD_W'(pos_reg);
    assign div_divisor  = kind_reg ? cycb_reg : CYCB_W'(n_val);
    assign div_addend   = kind_reg ? ACC_W'(n_val) : ACC_W'(cycb_reg);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        ok_next     = ok_reg;
        bps_next    = bps_reg;
        cycb_next   = cycb_reg;
        rem_next    = rem_reg;
        dacc_next   = dacc_reg;
        dur_next    = dur_reg;
        slot_next   = slot_reg;
        pre_next    = pre_reg;
        fbytes_next = fbytes_reg;
        off_next    = off_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    pos_next   = s_tdata[POS_W-1:0];
                    len_next   = s_tdata[S_TDATA_W-1:POS_W];
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                bps_next   = bps_full[BPS_W-1:0];
                len_next   = (len_reg > cfg.start) ? len_reg - cfg.start : '0;
                ok_next    = pos_reg < dur_reg;
                state_next = ST_CYC;
            end
            ST_CYC:
            begin
                cycb_next  = csamp * bps_reg;
                if (cfg.limit != '0 && len_reg > cfg.limit)
                begin
                    len_next = cfg.limit;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!kind_reg && !ok_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (kind_reg)
                    begin
                        rem_next   = div_rem;
                        dacc_next  = div_acc[COUNT_W-1:0];
                        slot_next  = '0;
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        slot_next  = div_rem[CAD_W-1:0];
                        off_next   = div_acc[OFF_W-1:0] + cfg.start[OFF_W-1:0];
                        state_next = ST_PRE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (slot_reg < n_val && rem_reg >= slot_bytes)
                begin
                    rem_next  = rem_reg - slot_bytes;
                    dacc_next = dacc_reg + 1'b1;
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    dur_next   = (cycb_reg == '0) ? '0 : dacc_reg;
                    state_next = ST_OUT;
                end
            end
            ST_PRE:
            begin
                pre_next    = pre_samples * bps_reg;
                fbytes_next = slot_bytes[FBYTES_W-1:0];
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                off_next   = off_reg + OFF_W'(pre_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_ok_next     = m_ok_reg;
        m_off_next    = m_off_reg;
        m_fbytes_next = m_fbytes_reg;
        m_samp_next   = m_samp_reg;
        m_count_next  = m_count_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_ok_next     = kind_reg | ok_reg;
            m_off_next    = loc_ok ? OFS_W'(off_reg) : '0;
            m_fbytes_next = loc_ok ? fbytes_reg : '0;
            m_samp_next   = (loc_ok && bps_reg != '0) ? slot_samples : '0;
            m_count_next  = dur_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dur_reg      <= dur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        ok_reg       <= ok_next;
        bps_reg      <= bps_next;
        cycb_reg     <= cycb_next;
        rem_reg      <= rem_next;
        dacc_reg     <= dacc_next;
        slot_reg     <= slot_next;
        pre_reg      <= pre_next;
        fbytes_reg   <= fbytes_next;
        off_reg      <= off_next;
        m_ok_reg     <= m_ok_next;
        m_off_reg    <= m_off_next;
        m_fbytes_reg <= m_fbytes_next;
        m_samp_reg   <= m_samp_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_samp_reg, m_fbytes_reg, m_off_reg};

    `AFCL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready,
        "second item accepted while one is at work")
    `AFCL_ASSERT_SAME(a_fail_zero, m_tvalid_reg && !m_ok_reg,
        m_off_reg == '0 && m_fbytes_reg == '0 && m_samp_reg == '0,
        "failed locate carries a non-zero position")
    `AFCL_ASSERT_SAME(a_bytes_samples, m_tvalid_reg,
        (m_fbytes_reg == '0) == (m_samp_reg == '0), "frame bytes and samples disagree")
    `AFCL_ASSERT_NEXT(a_dur_out, out_load && kind_reg, m_count_reg == dur_reg,
        "measure result does not match the stored duration")

endmodule
